// ===== design/cwsc_pkg.sv =====
// Shared constants, types and codes for the covering window substring counter.
package cwsc_pkg;

  localparam int MAX_TEXT    = 4096;
  localparam int MAX_PATTERN = 4096;
  localparam int ALPHABET    = 26;

  localparam int LETTER_W = 5;
  localparam int CMD_W    = 2;
  localparam int START_W  = 13;
  localparam int TOTAL_W  = 24;
  localparam int STATUS_W = 2;

  localparam int TEXT_AW = $clog2(MAX_TEXT);
  localparam int LEN_W   = $clog2(MAX_TEXT + 1);
  localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_TEXT    = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK           = 2'd0,
    STATUS_PAT_AFTER_TX = 2'd1,
    STATUS_TEXT_FULL    = 2'd2,
    STATUS_PAT_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_TEXT,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [LETTER_W-1:0] letter;
    logic                letter_ok;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP
  } state_e;

endpackage

// ===== design/cwsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/cwsc_front.sv =====
// Front end: takes input beats, classifies them and queues them for the back end.
module cwsc_front import cwsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [LETTER_W-1:0] letter_i,
  output logic                q_valid_o,
  output entry_t              q_entry_o,
  input  logic                q_pop_i
);

  entry_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr_q, wptr_d;
  logic [QUEUE_AW-1:0]  rptr_q, rptr_d;
  logic [QUEUE_CW-1:0]  count_q, count_d;
  entry_t               entry;
  logic                 push;
  logic                 pop;

  always_comb begin
    entry.letter    = letter_i;
    entry.letter_ok = (letter_i < LETTER_W'(ALPHABET));
    unique case (cmd_e'(command_i))
      CMD_CLEAR:   entry.op = OP_CLEAR;
      CMD_PATTERN: entry.op = OP_PATTERN;
      CMD_TEXT:    entry.op = OP_TEXT;
      default:     entry.op = OP_NONE;
    endcase
  end

  assign s_ready_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid_o = (count_q != '0);
  assign q_entry_o = mem_q[rptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_pop_i && q_valid_o;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= entry;
    end
  end

endmodule

// ===== design/cwsc_back.sv =====
// Back end: letter counts, left-edge sweep over the text store, result register.
module cwsc_back import cwsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  entry_t                q_entry_i,
  output logic                  q_pop_o,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [START_W-1:0]    starts_o,
  output logic [TOTAL_W-1:0]    total_o,
  output logic                  covered_o,
  output logic [STATUS_W-1:0]   status_o
);

  state_e               state_q, state_d;
  logic [PLEN_W-1:0]    need_q [ALPHABET];
  logic [PLEN_W-1:0]    need_d [ALPHABET];
  logic [LEN_W-1:0]     win_q  [ALPHABET];
  logic [LEN_W-1:0]     win_d  [ALPHABET];
  logic [PLEN_W-1:0]    deficit_q, deficit_d;
  logic [LEN_W-1:0]     left_q, left_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [PLEN_W-1:0]    plen_q, plen_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                 out_valid_q, out_valid_d;
  logic [START_W-1:0]   out_starts_q, out_starts_d;
  logic [TOTAL_W-1:0]   out_total_q, out_total_d;
  logic                 out_cov_q, out_cov_d;
  logic [STATUS_W-1:0]  out_status_q, out_status_d;

  logic                 slot_free;
  logic                 take;
  logic                 shrink;
  logic                 text_full;
  logic [LETTER_W-1:0]  old_letter;
  logic [LETTER_W-1:0]  rd_idx;
  logic                 rd_ok;
  logic [PLEN_W-1:0]    rd_need;
  logic [LEN_W-1:0]     rd_win;
  logic [TOTAL_W:0]     sum;
  logic                 ram_we;

  assign slot_free = !out_valid_q || m_ready_i;
  assign take      = (state_q == ST_IDLE) && q_valid_i && slot_free;
  assign q_pop_o   = take;
  assign shrink    = (deficit_q == '0) && (left_q < len_q);
  assign text_full = (len_q >= LEN_W'(MAX_TEXT));
  assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(left_q);

  assign rd_idx  = (state_q == ST_STEP) ? old_letter : q_entry_i.letter;
  assign rd_ok   = (rd_idx < LETTER_W'(ALPHABET));
  assign rd_need = rd_ok ? need_q[rd_idx] : '0;
  assign rd_win  = rd_ok ? win_q[rd_idx] : '0;

  assign ram_we = take && (q_entry_i.op == OP_TEXT) && !text_full && q_entry_i.letter_ok;

  cwsc_ram #(
    .WIDTH(LETTER_W),
    .DEPTH(MAX_TEXT)
  ) u_text_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(len_q[TEXT_AW-1:0]),
    .wdata_i(q_entry_i.letter),
    .raddr_i(left_q[TEXT_AW-1:0]),
    .rdata_o(old_letter)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (ram_we) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (shrink) begin
          state_d = ST_STEP;
        end else if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_STEP: begin
        state_d = ST_CHECK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    need_d       = need_q;
    win_d        = win_q;
    deficit_d    = deficit_q;
    left_d       = left_q;
    len_d        = len_q;
    plen_d       = plen_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_starts_d = out_starts_q;
    out_total_d  = out_total_q;
    out_cov_d    = out_cov_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          out_valid_d  = 1'b1;
          out_starts_d = '0;
          out_total_d  = total_q;
          out_cov_d    = 1'b0;
          out_status_d = STATUS_OK;
          unique case (q_entry_i.op)
            OP_CLEAR: begin
              for (int i = 0; i < ALPHABET; i++) begin
                need_d[i] = '0;
                win_d[i]  = '0;
              end
              deficit_d   = '0;
              left_d      = '0;
              len_d       = '0;
              plen_d      = '0;
              total_d     = '0;
              out_total_d = '0;
            end
            OP_PATTERN: begin
              if (len_q != '0) begin
                out_status_d = STATUS_PAT_AFTER_TX;
              end else if (plen_q >= PLEN_W'(MAX_PATTERN)) begin
                out_status_d = STATUS_PAT_FULL;
              end else if (q_entry_i.letter_ok) begin
                need_d[rd_idx] = rd_need + 1'b1;
                plen_d         = plen_q + 1'b1;
                deficit_d      = deficit_q + 1'b1;
              end
            end
            OP_TEXT: begin
              if (text_full) begin
                out_status_d = STATUS_TEXT_FULL;
              end else if (q_entry_i.letter_ok) begin
                out_valid_d   = out_valid_q && !m_ready_i;
                win_d[rd_idx] = rd_win + 1'b1;
                len_d         = len_q + 1'b1;
                if (PLEN_W'(rd_win) < rd_need) begin
                  deficit_d = deficit_q - 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (!shrink && slot_free) begin
          total_d      = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
          out_valid_d  = 1'b1;
          out_starts_d = START_W'(left_q);
          out_total_d  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
          out_cov_d    = (left_q != '0);
          out_status_d = STATUS_OK;
        end
      end
      ST_STEP: begin
        if (rd_ok) begin
          win_d[rd_idx] = rd_win - 1'b1;
          if (PLEN_W'(rd_win) <= rd_need) begin
            deficit_d = deficit_q + 1'b1;
          end
        end
        left_d = left_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      deficit_q   <= '0;
      left_q      <= '0;
      len_q       <= '0;
      plen_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ALPHABET; i++) begin
        need_q[i] <= '0;
        win_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      deficit_q   <= deficit_d;
      left_q      <= left_d;
      len_q       <= len_d;
      plen_q      <= plen_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      need_q      <= need_d;
      win_q       <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_starts_q <= out_starts_d;
    out_total_q  <= out_total_d;
    out_cov_q    <= out_cov_d;
    out_status_q <= out_status_d;
  end

  assign m_valid_o = out_valid_q;
  assign starts_o  = out_starts_q;
  assign total_o   = out_total_q;
  assign covered_o = out_cov_q;
  assign status_o  = out_status_q;

endmodule

// ===== design/covering_window_substring_counter.sv =====
// Top level of the covering window substring counter.
//
//   channel   dir  handshake        tdata (low bit up)                   tuser
//   s_axis    in   tvalid/tready    letter[4:0], pad[7:5]                command[1:0]
//   m_axis    out  tvalid/tready    starts[12:0] total[36:13] cov[37]    status[1:0]
//
// Clear, pattern and rejected beats take one back-end cycle after queueing.
// A text letter moves from idle to check; each left-edge step goes through step and
// back to check, a loop bound by the registered read of the text store.
// Reset clears all counts at once; the text store is not cleared.
// A 2-entry queue and the output register let each side stall on its own.
module covering_window_substring_counter import cwsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // letter[4:0], zero pad
  input  logic [CMD_W-1:0]      s_axis_tuser_i,   // command[1:0]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // starts, running_total, covered, pad
  output logic [STATUS_W-1:0]   m_axis_tuser_o    // status[1:0]
);

  logic               q_valid;
  entry_t             q_entry;
  logic               q_pop;
  logic [START_W-1:0] starts;
  logic [TOTAL_W-1:0] total;
  logic               covered;

  cwsc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .command_i(s_axis_tuser_i),
    .letter_i (s_axis_tdata_i[LETTER_W-1:0]),
    .q_valid_o(q_valid),
    .q_entry_o(q_entry),
    .q_pop_i  (q_pop)
  );

  cwsc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_entry_i(q_entry),
    .q_pop_o  (q_pop),
    .m_valid_o(m_axis_tvalid_o),
    .m_ready_i(m_axis_tready_i),
    .starts_o (starts),
    .total_o  (total),
    .covered_o(covered),
    .status_o (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(OUT_DATA_W - START_W - TOTAL_W - 1)'(0), covered, total, starts};

endmodule

// ===== design/cwsc_checker.sv =====
// Port-level checks for the covering window substring counter, bound to the top.
module cwsc_checker import cwsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic [CMD_W-1:0]      s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [STATUS_W-1:0]   m_axis_tuser_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=> s_axis_tvalid_i && $stable(s_axis_tdata_i)
      && $stable(s_axis_tuser_i))
    else $error("input beat changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o != STATUS_OK)
      |-> (m_axis_tdata_o[START_W-1:0] == '0) && !m_axis_tdata_o[START_W+TOTAL_W])
    else $error("rejected beat reports starts");

  a_cov_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[START_W+TOTAL_W] == (m_axis_tdata_o[START_W-1:0] != '0))
      && (m_axis_tdata_o[START_W-1:0] <= START_W'(MAX_TEXT)))
    else $error("covered flag disagrees with starts");

endmodule

bind covering_window_substring_counter cwsc_checker u_cwsc_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench for the covering window substring counter.
`timescale 1ns / 1ps

module testbench;
  import cwsc_pkg::*;

  typedef struct packed {
    logic [START_W-1:0]  starts;
    logic [TOTAL_W-1:0]  total;
    logic                covered;
    logic [STATUS_W-1:0] status;
  } count_beat_t;

  class window_count_board;
    int unsigned         need_cnt [ALPHABET];
    int unsigned         win_cnt [ALPHABET];
    logic [LETTER_W-1:0] history [MAX_TEXT];
    int unsigned         deficit;
    int unsigned         left_edge;
    int unsigned         text_len;
    int unsigned         pat_len;
    int unsigned         total;
    count_beat_t         expected_counts [$];
    int                  fail_count;

    function new();
      fail_count = 0;
      clear_counts();
    endfunction

    function void clear_counts();
      foreach (need_cnt[i]) begin
        need_cnt[i] = 0;
        win_cnt[i]  = 0;
      end
      deficit   = 0;
      left_edge = 0;
      text_len  = 0;
      pat_len   = 0;
      total     = 0;
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    function void note_beat(cmd_e cmd, logic [LETTER_W-1:0] letter);
      count_beat_t exp_beat;
      int unsigned old;
      int unsigned total_cap;
      exp_beat  = '0;
      total_cap = TOTAL_MAX;
      exp_beat.status = STATUS_OK;
      case (cmd)
        CMD_CLEAR: begin
          clear_counts();
        end
        CMD_PATTERN: begin
          if (text_len > 0) begin
            exp_beat.status = STATUS_PAT_AFTER_TX;
          end else if (pat_len >= MAX_PATTERN) begin
            exp_beat.status = STATUS_PAT_FULL;
          end else if (letter < ALPHABET) begin
            need_cnt[letter]++;
            pat_len++;
            deficit++;
          end
        end
        CMD_TEXT: begin
          if (text_len >= MAX_TEXT) begin
            exp_beat.status = STATUS_TEXT_FULL;
          end else if (letter < ALPHABET) begin
            history[text_len] = letter;
            text_len++;
            win_cnt[letter]++;
            if (win_cnt[letter] <= need_cnt[letter]) deficit--;
            // slide the left edge while the window still covers
            while (deficit == 0 && left_edge < text_len) begin
              old = history[left_edge];
              win_cnt[old]--;
              if (win_cnt[old] < need_cnt[old]) deficit++;
              left_edge++;
            end
            if (total_cap - total < left_edge) total = total_cap;
            else total += left_edge;
            exp_beat.starts  = START_W'(left_edge);
            exp_beat.covered = (left_edge > 0);
          end
        end
        default: begin
        end
      endcase
      exp_beat.total = TOTAL_W'(total);
      expected_counts.push_back(exp_beat);
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_beat(count_beat_t got);
      count_beat_t want;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %p", got));
        return;
      end
      want = expected_counts.pop_front();
      if (got.starts !== want.starts)
        report_mismatch($sformatf("starts got %0d want %0d", got.starts, want.starts));
      if (got.total !== want.total)
        report_mismatch($sformatf("total got %0d want %0d", got.total, want.total));
      if (got.covered !== want.covered)
        report_mismatch($sformatf("covered got %0b want %0b", got.covered, want.covered));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [CMD_W-1:0]      s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  window_count_board board = new();
  int                rx_hold = 0;
  int                beats_sent = 0;

  covering_window_substring_counter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input cmd_e cmd, input int letter, input bit quiet);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(IN_DATA_W-LETTER_W){1'b0}}, LETTER_W'(letter)};
    s_axis_tuser_i  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_beat(cmd, LETTER_W'(letter));
    beats_sent++;
  endtask

  task automatic wait_for_counts();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // clear, short pattern over a narrow letter range, then text mostly from that range
  task automatic send_cover_run(input int max_text, input bit force_quiet);
    int  span;
    int  base;
    int  plen;
    int  tlen;
    int  r;
    bit  quiet;
    quiet = force_quiet || ($urandom_range(0, 4) == 0);
    span  = $urandom_range(1, 5);
    base  = $urandom_range(0, ALPHABET - span);
    plen  = $urandom_range(0, 6);
    tlen  = $urandom_range(0, max_text);
    send_beat(CMD_CLEAR, $urandom_range(0, 31), quiet);
    repeat (plen) send_beat(CMD_PATTERN, base + $urandom_range(0, span - 1), quiet);
    repeat (tlen) begin
      r = $urandom_range(0, 39);
      if (r == 0) send_beat(CMD_UNUSED, $urandom_range(0, 31), quiet);
      else if (r == 1) send_beat(CMD_PATTERN, $urandom_range(0, 31), quiet);
      else if (r == 2) send_beat(CMD_TEXT, $urandom_range(ALPHABET, 31), quiet);
      else send_beat(CMD_TEXT, base + $urandom_range(0, span - 1), quiet);
    end
  endtask

  initial begin
    count_beat_t got;
    int          stall;
    int          tick;
    bit          rx_quiet;
    stall    = 0;
    tick     = 0;
    rx_quiet = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.starts  = m_axis_tdata_o[START_W-1:0];
        got.total   = m_axis_tdata_o[START_W +: TOTAL_W];
        got.covered = m_axis_tdata_o[START_W + TOTAL_W];
        got.status  = m_axis_tuser_o;
        board.check_beat(got);
      end
      tick++;
      if (tick % 128 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!rx_quiet) stall = pick_gap();
      end
    end
  end

  initial begin
    int start_count;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern with text letters, then rejected and ignored beats
    send_beat(CMD_CLEAR, 0, 1'b0);
    send_beat(CMD_TEXT, 0, 1'b0);
    send_beat(CMD_TEXT, 25, 1'b0);
    send_beat(CMD_TEXT, 3, 1'b0);
    send_beat(CMD_PATTERN, 1, 1'b0);
    send_beat(CMD_TEXT, 31, 1'b0);
    send_beat(CMD_UNUSED, 5, 1'b0);
    // pattern "aza" with an out-of-range letter, text short then covering
    send_beat(CMD_CLEAR, 31, 1'b0);
    send_beat(CMD_PATTERN, 0, 1'b0);
    send_beat(CMD_PATTERN, 25, 1'b0);
    send_beat(CMD_PATTERN, 0, 1'b0);
    send_beat(CMD_PATTERN, 26, 1'b0);
    send_beat(CMD_UNUSED, 31, 1'b0);
    send_beat(CMD_TEXT, 0, 1'b0);
    send_beat(CMD_TEXT, 25, 1'b0);
    send_beat(CMD_TEXT, 0, 1'b0);
    send_beat(CMD_TEXT, 0, 1'b0);
    send_beat(CMD_TEXT, 25, 1'b0);
    send_beat(CMD_TEXT, 16, 1'b0);
    send_beat(CMD_CLEAR, 0, 1'b0);
    wait_for_counts();

    // back-pressure: output held off while input keeps coming
    rx_hold = 400;
    repeat (3) send_cover_run(40, 1'b1);
    wait_for_counts();

    start_count = beats_sent;
    while (beats_sent - start_count < 800) begin
      if ($urandom_range(0, 9) < 7) begin
        send_cover_run(40, 1'b0);
      end else begin
        repeat (8) send_beat(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 31), 1'b0);
      end
      if ($urandom_range(0, 15) == 0) wait_for_counts();
    end

    wait_for_counts();
    repeat (20) @(posedge clk_i);
    if (board.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
